/* rtl/mcrb_pkg.sv */
// shared types and constants of the multichannel audio ring buffer
package mcrb_pkg;

	localparam int CW = 11;
	localparam int OPW = 3;
	localparam int IDXW = 10;
	localparam int CHW = 3;
	localparam int REGW = 1;
	localparam int NUM_LANES = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [OPW-1:0] OP_WRITE_COPY = 3'd0;
	localparam logic [OPW-1:0] OP_WRITE_ADD = 3'd1;
	localparam logic [OPW-1:0] OP_READ_COPY = 3'd2;
	localparam logic [OPW-1:0] OP_READ_ADD = 3'd3;
	localparam logic [OPW-1:0] OP_ADVANCE = 3'd4;

	localparam logic [REGW-1:0] REG_RING_LENGTH = 1'b0;
	localparam logic [REGW-1:0] REG_CHANNELS_USED = 1'b1;

	localparam logic [CW-1:0] RING_LENGTH_RESET = 11'd1024;
	localparam logic [CHW-1:0] CHANNELS_RESET = 3'd2;

	typedef struct packed {
		logic do_mem;
		logic [OPW-1:0] op;
		logic status;
		logic [CW-1:0] fill;
	} ctl_t;

	typedef struct packed {
		logic [CW-1:0] len;
		logic [CHW-1:0] nch;
	} cfg_state_t;

endpackage

/* rtl/mcrb_front.sv */
// front end: pointer and fill bookkeeping, checks and slot address of each word
module mcrb_front import mcrb_pkg::*; #(
	parameter int MAX_FRAMES = 1024,
	parameter int LANES = 4,
	parameter int AW = 10
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [REGW-1:0] cfg_index,
	input logic [CW-1:0] cfg_data,
	input logic push,
	input logic [OPW-1:0] operation,
	input logic [IDXW-1:0] frame_index,
	input logic [CW-1:0] frame_count,
	input logic advance_write,
	output ctl_t ctl,
	output logic [AW-1:0] addr,
	output cfg_state_t cfg
);

	localparam int SW = ((AW > CW) ? AW : CW) + 1;
	localparam logic [CW-1:0] LEN_RST =
		(32'(RING_LENGTH_RESET) > MAX_FRAMES) ? CW'(MAX_FRAMES) : RING_LENGTH_RESET;
	localparam logic [CHW-1:0] NCH_RST =
		(32'(CHANNELS_RESET) > LANES) ? CHW'(LANES) : CHANNELS_RESET;

	logic [AW-1:0] rp_q, wp_q;
	logic [CW-1:0] fill_q, len_q;
	logic [CHW-1:0] nch_q;

	logic [AW-1:0] rp_n, wp_n, rp_adv, wp_adv, base;
	logic [CW-1:0] fill_n, room;
	logic [SW-1:0] rsum, wsum, asum;
	logic is_wr, is_rd, last, err, do_mem;
	logic [CW-1:0] len_cfg;
	logic [CHW-1:0] nch_cfg;

	assign room = len_q - fill_q;
	assign is_wr = (operation == OP_WRITE_COPY) || (operation == OP_WRITE_ADD);
	assign is_rd = (operation == OP_READ_COPY) || (operation == OP_READ_ADD);
	assign last = ((CW'(frame_index) + CW'(1)) == frame_count);

	assign wsum = SW'(wp_q) + SW'(frame_count);
	assign rsum = SW'(rp_q) + SW'(frame_count);
	assign wp_adv = (wsum >= SW'(len_q)) ? AW'(wsum - SW'(len_q)) : AW'(wsum);
	assign rp_adv = (rsum >= SW'(len_q)) ? AW'(rsum - SW'(len_q)) : AW'(rsum);

	assign base = is_rd ? rp_q : wp_q;
	assign asum = SW'(base) + SW'(frame_index);
	assign addr = (asum >= SW'(len_q)) ? AW'(asum - SW'(len_q)) : AW'(asum);

	always_comb begin
		err = 1'b0;
		do_mem = 1'b0;
		rp_n = rp_q;
		wp_n = wp_q;
		fill_n = fill_q;
		case (operation)
			OP_ADVANCE: begin
				if (frame_count > room) begin
					err = 1'b1;
				end else begin
					wp_n = wp_adv;
					fill_n = fill_q + frame_count;
				end
			end
			OP_WRITE_COPY, OP_WRITE_ADD, OP_READ_COPY, OP_READ_ADD: begin
				if ((CW'(frame_index) >= frame_count) || (is_wr && (frame_count > room))
						|| (is_rd && (frame_count > fill_q))) begin
					err = 1'b1;
				end else begin
					do_mem = 1'b1;
					if (last && is_rd) begin
						rp_n = rp_adv;
						fill_n = fill_q - frame_count;
					end else if (last && advance_write) begin
						wp_n = wp_adv;
						fill_n = fill_q + frame_count;
					end
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	always_comb begin
		len_cfg = cfg_data;
		if (cfg_data == '0) begin
			len_cfg = CW'(1);
		end else if (32'(cfg_data) > MAX_FRAMES) begin
			len_cfg = CW'(MAX_FRAMES);
		end
		nch_cfg = cfg_data[CHW-1:0];
		if (cfg_data[CHW-1:0] == '0) begin
			nch_cfg = CHW'(1);
		end else if (32'(cfg_data[CHW-1:0]) > LANES) begin
			nch_cfg = CHW'(LANES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			len_q <= LEN_RST;
			nch_q <= NCH_RST;
		end else if (cfg_write) begin
			rp_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			case (cfg_index)
				REG_RING_LENGTH: begin
					len_q <= len_cfg;
				end
				REG_CHANNELS_USED: begin
					nch_q <= nch_cfg;
				end
				default: begin
				end
			endcase
		end else if (push) begin
			rp_q <= rp_n;
			wp_q <= wp_n;
			fill_q <= fill_n;
		end
	end

	assign ctl.do_mem = do_mem;
	assign ctl.op = operation;
	assign ctl.status = err;
	assign ctl.fill = fill_n;
	assign cfg.len = len_q;
	assign cfg.nch = nch_q;

endmodule

/* rtl/mcrb_queue.sv */
// short word queue between front and back end
module mcrb_queue import mcrb_pkg::*; #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] push_data,
	input logic pop,
	output logic head_valid,
	output logic [W-1:0] head_data,
	output logic full
);

	localparam int QPW = $clog2(QUEUE_DEPTH);

	logic [W-1:0] entry_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPW:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_data = entry_q[rd_ptr_q];
	assign full = (count_q == (QPW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

endmodule

/* rtl/mcrb_back.sv */
// back end: sample memory with clearing pass, read-modify-write and output register
module mcrb_back import mcrb_pkg::*; #(
	parameter int MAX_FRAMES = 1024,
	parameter int LANES = 4,
	parameter int AW = 10,
	parameter int SB = 24
) (
	input logic clk,
	input logic arst_n,
	input cfg_state_t cfg,
	input logic head_valid,
	input ctl_t head_ctl,
	input logic [AW-1:0] head_addr,
	input logic [LANES*SB-1:0] head_x,
	output logic pop,
	output logic clearing,
	output logic result_valid,
	input logic result_stall,
	output logic [NUM_LANES*SB-1:0] out_lanes,
	output logic status,
	output logic [CW-1:0] room_left,
	output logic [CW-1:0] frames_pending
);

	localparam int RW = LANES*SB;

	logic [RW-1:0] mem [MAX_FRAMES];

	logic clr_active_q;
	logic [AW-1:0] clr_addr_q;

	logic b1_valid_s1;
	ctl_t b1_ctl_s1;
	logic [AW-1:0] b1_addr_s1;
	logic [RW-1:0] b1_x_s1;
	logic [RW-1:0] rd_s1;

	logic lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	logic [RW-1:0] lw_data_q;

	logic out_valid_q, out_status_q;
	logic [NUM_LANES*SB-1:0] out_lanes_q;
	logic [CW-1:0] out_room_q, out_pend_q;

	logic advance, item_we, mem_we;
	logic [AW-1:0] mem_wa;
	logic [RW-1:0] old_row, new_row, mem_wd;
	logic [NUM_LANES*SB-1:0] res_row;

	function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a, input logic [SB-1:0] b);
		logic [SB:0] s;
		logic [SB-1:0] r;
		s = {a[SB-1], a} + {b[SB-1], b};
		r = s[SB-1:0];
		if (s[SB] != s[SB-1]) begin
			r = s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
		end
		return r;
	endfunction

	assign clearing = clr_active_q;
	assign advance = !out_valid_q || !result_stall;
	assign pop = advance && head_valid && !clr_active_q;
	assign item_we = advance && b1_valid_s1 && b1_ctl_s1.do_mem;

	assign old_row = (lw_valid_q && (lw_addr_q == b1_addr_s1)) ? lw_data_q : rd_s1;

	always_comb begin
		logic [SB-1:0] v, x, s;
		new_row = old_row;
		res_row = '0;
		for (int c = 0; c < LANES; c++) begin
			v = old_row[c*SB +: SB];
			x = b1_x_s1[c*SB +: SB];
			s = sat_add(v, x);
			if (b1_ctl_s1.do_mem && (CHW'(c) < cfg.nch)) begin
				case (b1_ctl_s1.op)
					OP_WRITE_COPY: begin
						new_row[c*SB +: SB] = x;
					end
					OP_WRITE_ADD: begin
						new_row[c*SB +: SB] = s;
					end
					OP_READ_COPY: begin
						new_row[c*SB +: SB] = '0;
						res_row[c*SB +: SB] = v;
					end
					OP_READ_ADD: begin
						new_row[c*SB +: SB] = '0;
						res_row[c*SB +: SB] = s;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign mem_we = clr_active_q || item_we;
	assign mem_wa = clr_active_q ? clr_addr_q : b1_addr_s1;
	assign mem_wd = clr_active_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rd_s1 <= mem[head_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			b1_ctl_s1 <= head_ctl;
			b1_addr_s1 <= head_addr;
			b1_x_s1 <= head_x;
		end
		if (item_we) begin
			lw_addr_q <= b1_addr_s1;
			lw_data_q <= new_row;
		end
		if (advance && b1_valid_s1) begin
			out_lanes_q <= res_row;
			out_status_q <= b1_ctl_s1.status;
			out_room_q <= cfg.len - b1_ctl_s1.fill;
			out_pend_q <= b1_ctl_s1.fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q <= '0;
			b1_valid_s1 <= 1'b0;
			lw_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MAX_FRAMES - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
			if (advance) begin
				b1_valid_s1 <= pop;
				out_valid_q <= b1_valid_s1;
			end
			if (item_we) begin
				lw_valid_q <= 1'b1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign out_lanes = out_lanes_q;
	assign status = out_status_q;
	assign room_left = out_room_q;
	assign frames_pending = out_pend_q;

endmodule

/* rtl/multichannel_audio_ring_buffer.sv */
// top level of the multichannel audio ring buffer
// One word per clock unless item_stall or result_stall holds the flow: the
// front end settles the status, the pointers and the slot address of a word
// in the cycle it is accepted and queues it; the back end reads the frame's
// row from the sample memory into a register, works the copy, saturating add
// or clearing read on every active lane in the b1 stage and writes the row
// back from there, forwarding the last written row to a word that hits the
// same frame. After reset a clearing pass zeroes the memory one frame a cycle
// while item_stall stays high; configuration writes are taken throughout.
module multichannel_audio_ring_buffer import mcrb_pkg::*; #(
	parameter int MAX_FRAMES = 1024,
	parameter int MAX_CHANNELS = 4,
	parameter int SAMPLE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [REGW-1:0] cfg_index,
	input logic [CW-1:0] cfg_data,
	input logic item_valid,
	output logic item_stall,
	input logic [OPW-1:0] operation,
	input logic [IDXW-1:0] frame_index,
	input logic [CW-1:0] frame_count,
	input logic advance_write,
	input logic signed [SAMPLE_BITS-1:0] ch0_in,
	input logic signed [SAMPLE_BITS-1:0] ch1_in,
	input logic signed [SAMPLE_BITS-1:0] ch2_in,
	input logic signed [SAMPLE_BITS-1:0] ch3_in,
	output logic result_valid,
	input logic result_stall,
	output logic signed [SAMPLE_BITS-1:0] ch0_out,
	output logic signed [SAMPLE_BITS-1:0] ch1_out,
	output logic signed [SAMPLE_BITS-1:0] ch2_out,
	output logic signed [SAMPLE_BITS-1:0] ch3_out,
	output logic status,
	output logic [CW-1:0] room_left,
	output logic [CW-1:0] frames_pending
);

	localparam int SB = SAMPLE_BITS;
	localparam int LANES = (MAX_CHANNELS < NUM_LANES) ? MAX_CHANNELS : NUM_LANES;
	localparam int AW = $clog2(MAX_FRAMES);
	localparam int CTW = $bits(ctl_t);
	localparam int QW = CTW + AW + LANES*SB;

	logic push, pop, q_full, head_valid, clearing;
	ctl_t push_ctl, head_ctl;
	cfg_state_t cfg;
	logic [AW-1:0] push_addr, head_addr;
	logic [NUM_LANES*SB-1:0] in_all, out_all;
	logic [LANES*SB-1:0] head_x;
	logic [QW-1:0] q_in, q_out;

	assign item_stall = clearing || q_full;
	assign push = item_valid && !item_stall;
	assign in_all = {ch3_in, ch2_in, ch1_in, ch0_in};

	mcrb_front #(
		.MAX_FRAMES(MAX_FRAMES),
		.LANES(LANES),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.operation(operation),
		.frame_index(frame_index),
		.frame_count(frame_count),
		.advance_write(advance_write),
		.ctl(push_ctl),
		.addr(push_addr),
		.cfg(cfg)
	);

	assign q_in = {push_ctl, push_addr, in_all[LANES*SB-1:0]};

	mcrb_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(q_in),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(q_out),
		.full(q_full)
	);

	assign head_ctl = q_out[QW-1 -: CTW];
	assign head_addr = q_out[LANES*SB +: AW];
	assign head_x = q_out[LANES*SB-1:0];

	mcrb_back #(
		.MAX_FRAMES(MAX_FRAMES),
		.LANES(LANES),
		.AW(AW),
		.SB(SB)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head_valid(head_valid),
		.head_ctl(head_ctl),
		.head_addr(head_addr),
		.head_x(head_x),
		.pop(pop),
		.clearing(clearing),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_lanes(out_all),
		.status(status),
		.room_left(room_left),
		.frames_pending(frames_pending)
	);

	assign ch0_out = out_all[0*SB +: SB];
	assign ch1_out = out_all[1*SB +: SB];
	assign ch2_out = out_all[2*SB +: SB];
	assign ch3_out = out_all[3*SB +: SB];

endmodule
